>>> design/fyrs_pkg.sv
// ----------------------------------------------------------------------------
// fyrs_pkg
// Shared types and constants of the Fisher-Yates row shuffler.
// ----------------------------------------------------------------------------
package fyrs_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = 5;

  localparam int LEN_REG_W  = 7;
  localparam int ROWS_REG_W = 5;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;

  localparam logic [LEN_REG_W-1:0]  LENGTH_RESET = 7'd12;
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET   = 5'd12;

  localparam logic CMD_INIT = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [WORD_W-1:0] rand_word;
  } in_item_t;

  typedef struct packed {
    logic [3:0] row_index;
    logic [5:0] position;
    logic [5:0] element;
    logic       last;
  } out_item_t;

endpackage

>>> design/fyrs_mod_unit.sv
// ----------------------------------------------------------------------------
// fyrs_mod_unit
// Restoring remainder unit: one dividend bit per cycle, from the most significant bit down.
// ----------------------------------------------------------------------------
module fyrs_mod_unit #(
  parameter int DVS_W = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fyrs_pkg::WORD_W-1:0] dividend,
  input  logic [DVS_W-1:0]          divisor,
  output logic                      done,
  output logic [DVS_W-1:0]          remainder
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [fyrs_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [fyrs_pkg::WORD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0]            dvs_r, dvs_nxt;
  logic [DVS_W-1:0]            rem_r, rem_nxt;
  logic [DVS_W:0]              trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[fyrs_pkg::WORD_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = fyrs_pkg::CNT_W'(fyrs_pkg::WORD_W - 1);
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DVS_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = DVS_W'(trial);
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

>>> design/fisher_yates_row_shuffler.sv
// ----------------------------------------------------------------------------
// fisher_yates_row_shuffler
// Keeps MAX_ROW_COUNT permutation rows in one memory and shuffles them in turn.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A shuffle step waits on the bit-serial
// remainder unit for rand_word mod (i+1), then does two reads and two writes on
// the permutation memory (one read port, one write port). When a row's pass ends
// the row is read out element by element (memory read, then output register),
// held while the output stalls. An initialise command sweeps all MAX_ROW_COUNT
// rows of MAX_LEN entries, one entry a cycle. The memory is undefined until the
// first initialise command.
module fisher_yates_row_shuffler #(
  parameter int MAX_LEN       = 64,
  parameter int MAX_ROW_COUNT = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  fyrs_pkg::in_item_t              in_data,
  output logic                            in_stall,
  output logic                            out_valid,
  output fyrs_pkg::out_item_t             out_data,
  input  logic                            out_stall,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fyrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fyrs_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int PW     = $clog2(MAX_LEN);
  localparam int LW     = $clog2(MAX_LEN + 1);
  localparam int RW     = (MAX_ROW_COUNT > 1) ? $clog2(MAX_ROW_COUNT) : 1;
  localparam int CW     = $clog2(MAX_ROW_COUNT + 1);
  localparam int AW     = RW + PW;
  localparam int DEPTH  = 2 ** AW;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_INIT  = 4'd1;
  localparam logic [3:0] ST_DIV   = 4'd2;
  localparam logic [3:0] ST_RDJ   = 4'd3;
  localparam logic [3:0] ST_RDI   = 4'd4;
  localparam logic [3:0] ST_WRJ   = 4'd5;
  localparam logic [3:0] ST_WRI   = 4'd6;
  localparam logic [3:0] ST_EMIT  = 4'd7;
  localparam logic [3:0] ST_ELOAD = 4'd8;

  logic [3:0]                      state_r, state_nxt;
  logic [fyrs_pkg::LEN_REG_W-1:0]  length_r, length_nxt;
  logic [fyrs_pkg::ROWS_REG_W-1:0] rows_r, rows_nxt;
  logic                            pend_r, pend_nxt;
  logic [RW-1:0]                   row_r, row_nxt;
  logic [PW-1:0]                   swap_r, swap_nxt;
  logic [PW-1:0]                   i_r, i_nxt;
  logic [PW-1:0]                   j_r, j_nxt;
  logic [PW-1:0]                   pos_r, pos_nxt;
  logic [RW-1:0]                   sw_row_r, sw_row_nxt;
  logic [PW-1:0]                   tmp_r, tmp_nxt;
  logic                            last_r, last_nxt;
  logic                            out_valid_r, out_valid_nxt;
  fyrs_pkg::out_item_t             out_r, out_nxt;

  logic [PW-1:0] mem [DEPTH];
  logic [PW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [PW-1:0] wr_data;
  logic          wr_en;

  logic [LW-1:0] eff_len;
  logic [CW-1:0] eff_rows;
  logic [fyrs_pkg::ROWS_REG_W-1:0] cfg_rows_val;
  logic [CW-1:0] cfg_rows_eff;
  logic [PW-1:0] len_m1;
  logic [PW-1:0] i_eff;
  logic [RW-1:0] row_eff;
  logic [RW-1:0] row_wrap;
  logic          in_acc, out_acc, cfg_acc;

  logic                         div_start;
  logic                         div_done;
  logic [LW-1:0]                div_rem;
  logic [LW-1:0]                div_dvs;

  fyrs_mod_unit #(
    .DVS_W(LW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_data.rand_word),
    .divisor  (div_dvs),
    .done     (div_done),
    .remainder(div_rem)
  );

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_rows_val = fyrs_pkg::ROWS_REG_W'(cfg_data);

  // out-of-range register values are clamped
  always_comb begin
    if (length_r == '0) begin
      eff_len = LW'(1);
    end else if (32'(length_r) > 32'(MAX_LEN)) begin
      eff_len = LW'(MAX_LEN);
    end else begin
      eff_len = LW'(length_r);
    end
    if (rows_r == '0) begin
      eff_rows = CW'(1);
    end else if (32'(rows_r) > 32'(MAX_ROW_COUNT)) begin
      eff_rows = CW'(MAX_ROW_COUNT);
    end else begin
      eff_rows = CW'(rows_r);
    end
    if (cfg_rows_val == '0) begin
      cfg_rows_eff = CW'(1);
    end else if (32'(cfg_rows_val) > 32'(MAX_ROW_COUNT)) begin
      cfg_rows_eff = CW'(MAX_ROW_COUNT);
    end else begin
      cfg_rows_eff = CW'(cfg_rows_val);
    end
  end

  assign len_m1   = PW'(eff_len - 1'b1);
  assign i_eff    = pend_r ? len_m1 : swap_r;
  assign row_eff  = (pend_r && (CW'(row_r) >= eff_rows)) ? '0 : row_r;
  assign row_wrap = ((CW'(row_r) + 1'b1) >= eff_rows) ? '0 : RW'(row_r + 1'b1);
  assign div_dvs  = LW'(i_eff) + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    length_nxt    = length_r;
    rows_nxt      = rows_r;
    pend_nxt      = pend_r;
    row_nxt       = row_r;
    swap_nxt      = swap_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pos_nxt       = pos_r;
    sw_row_nxt    = sw_row_r;
    tmp_nxt       = tmp_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_acc;
    out_nxt       = out_r;
    div_start     = 1'b0;
    rd_addr       = {row_r, pos_r};
    wr_addr       = {sw_row_r, pos_r};
    wr_data       = pos_r;
    wr_en         = 1'b0;

    // a register write restarts the pass of the current row
    if (cfg_acc) begin
      case (cfg_index)
        fyrs_pkg::CFG_LENGTH: begin
          length_nxt = fyrs_pkg::LEN_REG_W'(cfg_data);
          pend_nxt   = 1'b1;
        end
        fyrs_pkg::CFG_ROWS: begin
          rows_nxt = cfg_rows_val;
          pend_nxt = 1'b1;
          // the current row wraps at once if it falls out of use
          if (CW'(row_r) >= cfg_rows_eff) begin
            row_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.cmd == fyrs_pkg::CMD_INIT) begin
            row_nxt    = '0;
            pend_nxt   = 1'b1;
            sw_row_nxt = '0;
            pos_nxt    = '0;
            state_nxt  = ST_INIT;
          end else begin
            pend_nxt = 1'b0;
            row_nxt  = row_eff;
            i_nxt    = i_eff;
            pos_nxt  = '0;
            if (i_eff == '0) begin
              state_nxt = ST_EMIT;
            end else begin
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
          end
        end
      end
      ST_INIT: begin
        wr_en = 1'b1;
        if (pos_r == PW'(MAX_LEN - 1)) begin
          pos_nxt    = '0;
          sw_row_nxt = RW'(sw_row_r + 1'b1);
          if (sw_row_r == RW'(MAX_ROW_COUNT - 1)) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          pos_nxt = PW'(pos_r + 1'b1);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          j_nxt     = PW'(div_rem);
          state_nxt = ST_RDJ;
        end
      end
      ST_RDJ: begin
        rd_addr   = {row_r, j_r};
        state_nxt = ST_RDI;
      end
      ST_RDI: begin
        tmp_nxt   = rd_data_r;
        rd_addr   = {row_r, i_r};
        state_nxt = ST_WRJ;
      end
      ST_WRJ: begin
        wr_en     = 1'b1;
        wr_addr   = {row_r, j_r};
        wr_data   = rd_data_r;
        state_nxt = ST_WRI;
      end
      ST_WRI: begin
        wr_en    = 1'b1;
        wr_addr  = {row_r, i_r};
        wr_data  = tmp_r;
        swap_nxt = PW'(i_r - 1'b1);
        pos_nxt  = '0;
        if (i_r == PW'(1)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        // read only once the output register is free by the time data lands
        rd_addr = {row_r, pos_r};
        if (!out_valid_r || !out_stall) begin
          last_nxt  = (pos_r == len_m1);
          state_nxt = ST_ELOAD;
        end
      end
      ST_ELOAD: begin
        out_valid_nxt     = 1'b1;
        out_nxt.row_index = 4'(row_r);
        out_nxt.position  = 6'(pos_r);
        out_nxt.element   = 6'(rd_data_r);
        out_nxt.last      = last_r;
        if (last_r) begin
          row_nxt   = row_wrap;
          swap_nxt  = len_m1;
          state_nxt = ST_IDLE;
        end else begin
          pos_nxt   = PW'(pos_r + 1'b1);
          state_nxt = ST_EMIT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      length_r    <= fyrs_pkg::LENGTH_RESET;
      rows_r      <= fyrs_pkg::ROWS_RESET;
      pend_r      <= 1'b1;
      row_r       <= '0;
      swap_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      length_r    <= length_nxt;
      rows_r      <= rows_nxt;
      pend_r      <= pend_nxt;
      row_r       <= row_nxt;
      swap_r      <= swap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    pos_r    <= pos_nxt;
    sw_row_r <= sw_row_nxt;
    tmp_r    <= tmp_nxt;
    last_r   <= last_nxt;
    out_r    <= out_nxt;
  end

endmodule
